@@ sv/multiturn_angle_velocity_tracker_macros.svh @@
// assertion macros for the multiturn angle and velocity tracker
// used by mavt_ctrl, the module that carries concurrent assertions; no other dependencies
`ifndef MULTITURN_ANGLE_VELOCITY_TRACKER_MACROS_SVH
`define MULTITURN_ANGLE_VELOCITY_TRACKER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MAVT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mavt assertion failed");

// next-cycle implication, disabled while reset is low
`define MAVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mavt assertion failed");

`endif

@@ sv/mavt_pkg.sv @@
// shared widths, codes, reset values and controller/datapath command types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mavt_pkg;

    localparam int TIMER_BITS_DEF = 24;

    localparam int OP_W       = 2;
    localparam int RAW_W      = 16;
    localparam int TS_W       = 24;
    localparam int FULL_W     = 48;
    localparam int VEL_W      = 32;
    localparam int TURN_W     = 32;
    localparam int CPR_W      = 17;
    localparam int TPU_W      = 8;
    localparam int TICK_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int MAG_W  = FULL_W + 1;
    localparam int K_W    = 28;
    localparam int PROD_W = MAG_W + K_W;
    localparam int LO_W   = 25;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 29;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int QUO_W  = 32;
    localparam int CNT_W  = $clog2(QUO_W);

    localparam logic [OP_W-1:0] OP_ANGLE = 2'd0;
    localparam logic [OP_W-1:0] OP_VEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CPR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPU  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXI = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB   = 2'd3;

    localparam logic [CPR_W-1:0]  CPR_RST  = 17'd16384;
    localparam logic [TPU_W-1:0]  TPU_RST  = 8'd9;
    localparam logic [TICK_W-1:0] MAXI_RST = 24'd4500000;
    localparam logic [TICK_W-1:0] FB_RST   = 24'd9000;

    localparam logic [CPR_W-1:0] CPR_MIN = 17'd2;
    localparam logic [CPR_W-1:0] CPR_MAX = 17'd65536;

    localparam logic [K_W-1:0] US_PER_S = 28'd1000000;

    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};

    localparam logic [VEL_W-1:0] VEL_POS_LIM = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_NEG_LIM = 32'h8000_0000;

    typedef struct packed {
        logic load;
        logic angle;
        logic full;
        logic mag;
        logic mul_lo;
        logic mul_hi;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic op_init;
        logic op_vel;
        logic div_done;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ sv/multiturn_angle_velocity_tracker.sv @@
// Multi-turn encoder angle tracker with velocity estimate. Each item carries a
// raw absolute angle, a down-counting timestamp and an operation: angle sample,
// angle and velocity sample, or tracker init. The block works on one item at a
// time: an init item passes the angle state, an angle item the angle and
// full-angle states, and a velocity item also the magnitude, the two passes of
// the shared 33x29 multiplier and the 32-step radix-2 divider that forms counts
// per second. The result sits in an output register; the next item can be
// accepted in the cycle after the previous result has been loaded there.
// Configuration registers (index 0 counts per revolution, 1 ticks per
// microsecond, 2 longest interval, 3 fallback interval) are written through the
// plain write port; the user must write them only while no item is in flight,
// which the block itself does not enforce. Depends on mavt_pkg, mavt_ctrl and mavt_dp.
`timescale 1ns / 1ps
`default_nettype none

module multiturn_angle_velocity_tracker #(
    parameter int TIMER_BITS = mavt_pkg::TIMER_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mavt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mavt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [mavt_pkg::OP_W-1:0]       i_operation,
    input  wire logic [mavt_pkg::RAW_W-1:0]      i_raw_angle,
    input  wire logic [mavt_pkg::TS_W-1:0]       i_timestamp,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [mavt_pkg::FULL_W-1:0]   o_full_angle,
    output logic signed [mavt_pkg::VEL_W-1:0]    o_velocity,
    output logic                                 o_velocity_saturated,
    output logic                                 o_interval_fallback
);
    import mavt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    mavt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mavt_dp #(
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_operation          (i_operation),
        .i_raw_angle          (i_raw_angle),
        .i_timestamp          (i_timestamp),
        .o_full_angle         (o_full_angle),
        .o_velocity           (o_velocity),
        .o_velocity_saturated (o_velocity_saturated),
        .o_interval_fallback  (o_interval_fallback)
    );

endmodule

`default_nettype wire

@@ sv/mavt_ctrl.sv @@
// sequencing state machine: handshakes and datapath commands
// depends on mavt_pkg and multiturn_angle_velocity_tracker_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "multiturn_angle_velocity_tracker_macros.svh"

module mavt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire mavt_pkg::t_dp_sts i_sts,
    output mavt_pkg::t_dp_cmd      o_cmd
);
    import mavt_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ANGLE    = 4'd1;
    localparam logic [3:0] S_FULL     = 4'd2;
    localparam logic [3:0] S_MAG      = 4'd3;
    localparam logic [3:0] S_MUL_LO   = 4'd4;
    localparam logic [3:0] S_MUL_HI   = 4'd5;
    localparam logic [3:0] S_DIV_INIT = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_load;

    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.angle    = (r_state == S_ANGLE);
        o_cmd.full     = (r_state == S_FULL);
        o_cmd.mag      = (r_state == S_MAG);
        o_cmd.mul_lo   = (r_state == S_MUL_LO);
        o_cmd.mul_hi   = (r_state == S_MUL_HI);
        o_cmd.div_init = (r_state == S_DIV_INIT);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = out_load;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_ANGLE;
            end
            S_ANGLE: begin
                n_state = i_sts.op_init ? S_OUT : S_FULL;
            end
            S_FULL: begin
                n_state = i_sts.op_vel ? S_MAG : S_OUT;
            end
            S_MAG:      n_state = S_MUL_LO;
            S_MUL_LO:   n_state = S_MUL_HI;
            S_MUL_HI:   n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = out_load ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `MAVT_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_ANGLE)
    `MAVT_ASSERT_SAME(a_div_only_vel, i_clk, i_rst_n, r_state == S_DIV, i_sts.op_vel)
    `MAVT_ASSERT_NEXT(a_init_short, i_clk, i_rst_n, (r_state == S_ANGLE) && i_sts.op_init, r_state == S_OUT)
    `MAVT_ASSERT_NEXT(a_out_waits, i_clk, i_rst_n, (r_state == S_OUT) && r_out_valid && i_out_stall, r_state == S_OUT)

endmodule

`default_nettype wire

@@ sv/mavt_dp.sv @@
// datapath: config registers, turn tracking, interval, shared multiplier,
// radix-2 divider and output payload registers; depends on mavt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mavt_dp #(
    parameter int TIMER_BITS = mavt_pkg::TIMER_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mavt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mavt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire mavt_pkg::t_dp_cmd                   i_cmd,
    output mavt_pkg::t_dp_sts                        o_sts,
    input  wire logic [mavt_pkg::OP_W-1:0]           i_operation,
    input  wire logic [mavt_pkg::RAW_W-1:0]          i_raw_angle,
    input  wire logic [mavt_pkg::TS_W-1:0]           i_timestamp,
    output logic signed [mavt_pkg::FULL_W-1:0]       o_full_angle,
    output logic signed [mavt_pkg::VEL_W-1:0]        o_velocity,
    output logic                                     o_velocity_saturated,
    output logic                                     o_interval_fallback
);
    import mavt_pkg::*;

    localparam int IW = (TIMER_BITS > TS_W) ? TIMER_BITS : TS_W;
    localparam logic [IW-1:0] TMASK = IW'((65'd1 << TIMER_BITS) - 65'd1);

    // configuration
    logic [CPR_W-1:0]  r_cpr;
    logic [TPU_W-1:0]  r_tpu;
    logic [TICK_W-1:0] r_maxi;
    logic [TICK_W-1:0] r_fb;

    // tracker state
    logic [RAW_W-1:0]         r_prev_raw;
    logic signed [TURN_W-1:0] r_turn;
    logic signed [FULL_W-1:0] r_prev_full;
    logic [TIMER_BITS-1:0]    r_prev_ts;

    // per-item work registers
    logic [OP_W-1:0]          r_op;
    logic [RAW_W-1:0]         r_raw;
    logic [IW-1:0]            r_now;
    logic [TICK_W-1:0]        r_ival;
    logic                     r_fbk;
    logic [K_W-1:0]           r_k;
    logic signed [FULL_W-1:0] r_full;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_acc;
    logic                     r_big;
    logic [TICK_W-1:0]        r_rem;
    logic [CNT_W-1:0]         r_cnt;

    logic [CPR_W-1:0]          cpr_eff;
    logic signed [RAW_W:0]     d_raw;
    logic [RAW_W-1:0]          ad;
    logic [RAW_W+2:0]          ad5;
    logic                      wrap;
    logic signed [TURN_W-1:0]  n_turn;
    logic [IW-1:0]             prev_ext;
    logic [IW-1:0]             ival_raw;
    logic                      n_fb;
    logic [TICK_W-1:0]         n_ival;
    logic [K_W-1:0]            n_k;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [PROD_W-1:0]         mul_ext;
    logic signed [FULL_W-1:0]  n_full;
    logic signed [MAG_W-1:0]   d_full;
    logic [MAG_W-1:0]          n_mag;
    logic [TICK_W:0]           rem2;
    logic                      q_bit;
    logic [TICK_W-1:0]         n_rem;
    logic [QUO_W-1:0]          quo;
    logic [VEL_W-1:0]          n_vel;
    logic                      n_sat;

    assign o_sts.op_init  = (r_op == OP_INIT);
    assign o_sts.op_vel   = (r_op == OP_VEL);
    assign o_sts.div_done = (r_cnt == '0);

    // turn tracking
    always_comb begin
        priority if (r_cpr < CPR_MIN) cpr_eff = CPR_MIN;
        else if (r_cpr > CPR_MAX)     cpr_eff = CPR_MAX;
        else                          cpr_eff = r_cpr;
    end

    assign d_raw = $signed({1'b0, r_raw}) - $signed({1'b0, r_prev_raw});
    assign ad    = d_raw[RAW_W] ? RAW_W'(-d_raw) : d_raw[RAW_W-1:0];
    assign ad5   = (RAW_W+3)'({ad, 2'b00}) + (RAW_W+3)'(ad);
    assign wrap  = ad5 > {cpr_eff, 2'b00};

    always_comb begin
        n_turn = r_turn;
        if (wrap && !d_raw[RAW_W]) begin
            if (r_turn != TURN_MIN) n_turn = r_turn - 32'sd1;
        end else if (wrap) begin
            if (r_turn != TURN_MAX) n_turn = r_turn + 32'sd1;
        end
    end

    // interval on the wrapping down-counter
    assign prev_ext = IW'(r_prev_ts);

    always_comb begin
        if (r_now < prev_ext) ival_raw = prev_ext - r_now;
        else                  ival_raw = TMASK - r_now + prev_ext;
    end

    assign n_fb   = (ival_raw == '0) || (ival_raw > IW'(r_maxi));
    assign n_ival = n_fb ? ((r_fb == '0) ? TICK_W'(1) : r_fb) : ival_raw[TICK_W-1:0];
    assign n_k    = K_W'(r_tpu) * US_PER_S;

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        priority if (i_cmd.full) begin
            mul_a = MUL_A_W'(r_turn);
            mul_b = $signed(MUL_B_W'(cpr_eff));
        end else if (i_cmd.mul_lo) begin
            mul_a = $signed(MUL_A_W'(r_mag[LO_W-1:0]));
            mul_b = $signed(MUL_B_W'(r_k));
        end else if (i_cmd.mul_hi) begin
            mul_a = $signed(MUL_A_W'(r_mag[MAG_W-1:LO_W]));
            mul_b = $signed(MUL_B_W'(r_k));
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_ext = PROD_W'(unsigned'(mul_p));
    assign n_full  = mul_p[FULL_W-1:0] + $signed(FULL_W'(r_raw));

    assign d_full = $signed({r_full[FULL_W-1], r_full})
                  - $signed({r_prev_full[FULL_W-1], r_prev_full});
    assign n_mag  = d_full[MAG_W-1] ? MAG_W'(-d_full) : MAG_W'(d_full);

    // restoring divider step
    assign rem2  = {r_rem, r_acc[QUO_W-1]};
    assign q_bit = rem2 >= {1'b0, r_ival};
    assign n_rem = q_bit ? TICK_W'(rem2 - {1'b0, r_ival}) : rem2[TICK_W-1:0];
    assign quo   = r_acc[QUO_W-1:0];

    // velocity clipping
    always_comb begin
        n_vel = '0;
        n_sat = 1'b0;
        if (o_sts.op_vel) begin
            priority if (!r_neg) begin
                if (r_big || (quo > VEL_POS_LIM)) begin
                    n_vel = VEL_POS_LIM;
                    n_sat = 1'b1;
                end else begin
                    n_vel = quo;
                end
            end else begin
                if (r_big || (quo > VEL_NEG_LIM)) begin
                    n_vel = VEL_NEG_LIM;
                    n_sat = 1'b1;
                end else begin
                    n_vel = VEL_W'(0) - quo;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr       <= CPR_RST;
            r_tpu       <= TPU_RST;
            r_maxi      <= MAXI_RST;
            r_fb        <= FB_RST;
            r_prev_raw  <= '0;
            r_turn      <= '0;
            r_prev_full <= '0;
            r_prev_ts   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CPR:  r_cpr  <= i_cfg_data[CPR_W-1:0];
                    CFG_TPU:  r_tpu  <= i_cfg_data[TPU_W-1:0];
                    CFG_MAXI: r_maxi <= i_cfg_data[TICK_W-1:0];
                    CFG_FB:   r_fb   <= i_cfg_data[TICK_W-1:0];
                    default:  r_fb   <= r_fb;
                endcase
            end
            if (i_cmd.angle) begin
                r_prev_raw <= r_raw;
                if (o_sts.op_init) begin
                    r_turn      <= '0;
                    r_prev_full <= $signed(FULL_W'(r_raw));
                    r_prev_ts   <= '0;
                end else begin
                    r_turn <= n_turn;
                end
            end
            if (i_cmd.mag) begin
                r_prev_full <= r_full;
                r_prev_ts   <= r_now[TIMER_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_raw <= i_raw_angle;
            r_now <= IW'(i_timestamp) & TMASK;
        end
        if (i_cmd.angle) begin
            r_full <= $signed(FULL_W'(r_raw));
            r_ival <= n_ival;
            r_fbk  <= n_fb;
            r_k    <= n_k;
        end else if (i_cmd.full) begin
            r_full <= n_full;
        end
        if (i_cmd.mag) begin
            r_mag <= n_mag;
            r_neg <= d_full[MAG_W-1];
        end
        if (i_cmd.mul_lo) begin
            r_acc <= mul_ext;
        end else if (i_cmd.mul_hi) begin
            r_acc <= r_acc + (mul_ext << LO_W);
        end else if (i_cmd.div_init) begin
            r_big <= r_acc[PROD_W-1:QUO_W] >= (PROD_W-QUO_W)'(r_ival);
            r_rem <= r_acc[QUO_W+TICK_W-1:QUO_W];
            r_cnt <= CNT_W'(QUO_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_acc[QUO_W-1:0] <= {r_acc[QUO_W-2:0], q_bit};
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            o_full_angle         <= r_full;
            o_velocity           <= $signed(n_vel);
            o_velocity_saturated <= n_sat;
            o_interval_fallback  <= o_sts.op_vel && r_fbk;
        end
    end

endmodule

`default_nettype wire

@@ test/multiturn_angle_velocity_tracker_test.sv @@
// self-checking testbench for the multi-turn angle and velocity tracker
// directed rows then random encoder sequences under several register settings
// depends on mavt_pkg and multiturn_angle_velocity_tracker
`timescale 1ns / 1ps

module multiturn_angle_velocity_tracker_test;
    import mavt_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam longint unsigned TIMER_MASK = (64'd1 << TIMER_BITS_DEF) - 64'd1;
    localparam longint unsigned QUOTIENT_CEIL = 64'h1_0000_0000;
    localparam longint unsigned SPEED_HUGE = 64'h100_0000_0000;
    localparam int ITEMS_PER_SETTING = 180;
    localparam int SETTINGS_COUNT = 6;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 48;

    typedef struct packed {
        logic signed [FULL_W-1:0] full_angle;
        logic signed [VEL_W-1:0]  velocity;
        logic                     velocity_saturated;
        logic                     interval_fallback;
    } t_tracker_result;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [RAW_W-1:0] raw;
        logic [TS_W-1:0]  ts;
        logic             known;
        t_tracker_result  res;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [OP_W-1:0]           i_operation = '0;
    logic [RAW_W-1:0]          i_raw_angle = '0;
    logic [TS_W-1:0]           i_timestamp = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [FULL_W-1:0]  o_full_angle;
    logic signed [VEL_W-1:0]   o_velocity;
    logic                      o_velocity_saturated;
    logic                      o_interval_fallback;

    // register shadows
    logic [CPR_W-1:0]  cfg_cpr = CPR_RST;
    logic [TPU_W-1:0]  cfg_tpu = TPU_RST;
    logic [TICK_W-1:0] cfg_max_ivl = MAXI_RST;
    logic [TICK_W-1:0] cfg_fallback = FB_RST;

    // tracker state
    logic [RAW_W-1:0] trk_prev_raw = '0;
    longint           trk_turns = 0;
    longint           trk_prev_full = 0;
    longint unsigned  trk_prev_ts = 0;

    // encoder sequence generator
    longint gen_raw = 0;
    longint gen_ts = 0;

    t_tracker_result expected_q[$];
    t_stim_row       directed_rows[$];
    int              mismatch_count = 0;
    int              results_checked = 0;
    int              sat_results = 0;
    int              fb_results = 0;
    int              op_seen [4];
    int              snd_idle_pct = 18;
    int              rcv_idle_pct = 57;

    multiturn_angle_velocity_tracker u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_operation          (i_operation),
        .i_raw_angle          (i_raw_angle),
        .i_timestamp          (i_timestamp),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_full_angle         (o_full_angle),
        .o_velocity           (o_velocity),
        .o_velocity_saturated (o_velocity_saturated),
        .o_interval_fallback  (o_interval_fallback)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 60)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic longint rev_counts();
        logic [CPR_W-1:0] c;
        longint cpr;
        c = cfg_cpr;
        if (c < CPR_MIN)
            c = CPR_MIN;
        else if (c > CPR_MAX)
            c = CPR_MAX;
        cpr = longint'(c);
        return cpr;
    endfunction

    // turn counting on a 0.8 revolution jump, returns the multi-turn angle
    function automatic longint track_full(input logic [RAW_W-1:0] raw);
        longint cpr;
        longint raw_l;
        longint prev_l;
        longint d;
        longint ad;
        cpr = rev_counts();
        raw_l = longint'(raw);
        prev_l = longint'(trk_prev_raw);
        d = raw_l - prev_l;
        ad = (d < 0) ? -d : d;
        if (5 * ad > 4 * cpr) begin
            if (d > 0) begin
                if (trk_turns > TURN_MIN)
                    trk_turns--;
            end else if (trk_turns < TURN_MAX) begin
                trk_turns++;
            end
        end
        trk_prev_raw = raw;
        return trk_turns * cpr + raw_l;
    endfunction

    function automatic t_tracker_result predict_tracker(input logic [OP_W-1:0] op,
            input logic [RAW_W-1:0] raw, input logic [TS_W-1:0] ts);
        t_tracker_result r;
        longint full;
        longint dfull;
        longint unsigned now;
        longint unsigned ivl;
        longint unsigned mag;
        longint unsigned k;
        longint unsigned qa;
        longint unsigned ra;
        longint unsigned q;
        r = '0;
        now = 64'(ts);
        case (op)
            OP_INIT: begin
                trk_turns = 0;
                trk_prev_raw = raw;
                trk_prev_full = longint'(raw);
                trk_prev_ts = 0;
                r.full_angle = FULL_W'(raw);
            end
            OP_VEL: begin
                if (now < trk_prev_ts)
                    ivl = trk_prev_ts - now;
                else
                    ivl = TIMER_MASK - now + trk_prev_ts;
                if (ivl == 0 || ivl > cfg_max_ivl) begin
                    ivl = (cfg_fallback == 0) ? 64'd1 : 64'(cfg_fallback);
                    r.interval_fallback = 1'b1;
                end
                full = track_full(raw);
                dfull = full - trk_prev_full;
                mag = (dfull < 0) ? -dfull : dfull;
                k = 64'(cfg_tpu);
                k = k * US_PER_S;
                qa = mag / ivl;
                ra = mag % ivl;
                if (k != 0 && qa >= QUOTIENT_CEIL)
                    q = SPEED_HUGE;
                else
                    q = qa * k + (ra * k) / ivl;
                if (dfull >= 0) begin
                    if (q > VEL_POS_LIM) begin
                        q = VEL_POS_LIM;
                        r.velocity_saturated = 1'b1;
                    end
                end else begin
                    if (q > VEL_NEG_LIM) begin
                        q = VEL_NEG_LIM;
                        r.velocity_saturated = 1'b1;
                    end
                    q = 64'd0 - q;
                end
                r.velocity = q[VEL_W-1:0];
                r.full_angle = FULL_W'(full);
                trk_prev_full = full;
                trk_prev_ts = now;
            end
            default: begin
                r.full_angle = FULL_W'(track_full(raw));
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
            input logic [TS_W-1:0] ts, input logic known,
            input logic signed [FULL_W-1:0] full, input logic signed [VEL_W-1:0] vel,
            input logic sat, input logic fb);
        t_stim_row row;
        row.op = op;
        row.raw = raw;
        row.ts = ts;
        row.known = known;
        row.res.full_angle = full;
        row.res.velocity = vel;
        row.res.velocity_saturated = sat;
        row.res.interval_fallback = fb;
        directed_rows.push_back(row);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw,
            input logic [TS_W-1:0] ts, input logic known, input t_tracker_result typed);
        t_tracker_result guess;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_raw_angle <= raw;
        i_timestamp <= ts;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        guess = predict_tracker(op, raw, ts);
        expected_q.push_back(known ? typed : guess);
        op_seen[op]++;
    endtask

    // hold off new items until the block has delivered everything
    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            report_mismatch("results never delivered", expected_q.size(), 0);
            expected_q.delete();
        end
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] cpr, input logic [CFG_DATA_W-1:0] tpu,
            input logic [CFG_DATA_W-1:0] max_ivl, input logic [CFG_DATA_W-1:0] fallback);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idx [4];
        vals[0] = cpr;
        vals[1] = tpu;
        vals[2] = max_ivl;
        vals[3] = fallback;
        idx[0] = CFG_CPR;
        idx[1] = CFG_TPU;
        idx[2] = CFG_MAXI;
        idx[3] = CFG_FB;
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            case (idx[i])
                CFG_CPR:  cfg_cpr = vals[i][CPR_W-1:0];
                CFG_TPU:  cfg_tpu = vals[i][TPU_W-1:0];
                CFG_MAXI: cfg_max_ivl = vals[i][TICK_W-1:0];
                CFG_FB:   cfg_fallback = vals[i][TICK_W-1:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // mostly a rotating encoder with a running down-counter, some pure noise
    task automatic next_random_item(output logic [OP_W-1:0] op, output logic [RAW_W-1:0] raw,
            output logic [TS_W-1:0] ts);
        longint cpr;
        longint span;
        longint pos;
        longint dt;
        int unsigned pick;
        cpr = rev_counts();
        ts = TS_W'($urandom_range(0, 24'hFF_FFFF));
        if ($urandom_range(99) < 15) begin
            op = OP_W'($urandom_range(0, 3));
            raw = RAW_W'($urandom_range(0, 16'hFFFF));
            return;
        end
        pick = $urandom_range(99);
        op = (pick < 45) ? OP_ANGLE : (pick < 90) ? OP_VEL : (pick < 95) ? OP_INIT : OP_SPARE;
        span = ($urandom_range(9) == 0) ? cpr - 1 : cpr * 3 / 10;
        pos = longint'($urandom_range(0, 32'(span)));
        if ($urandom_range(1))
            pos = -pos;
        pos = (gen_raw + pos) % cpr;
        if (pos < 0)
            pos += cpr;
        gen_raw = pos;
        raw = RAW_W'(pos);
        if (op == OP_INIT) begin
            gen_ts = TIMER_MASK;
        end else if (op == OP_VEL) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                dt = 0;
            end else if (pick < 30) begin
                dt = $urandom_range(1, 4);
            end else if (pick < 70) begin
                dt = $urandom_range(1, 20000);
            end else if (pick < 85) begin
                dt = cfg_max_ivl;
                dt = dt + $urandom_range(0, 2) - 1;
            end else begin
                dt = $urandom_range(0, 24'hFF_FFFF);
            end
            gen_ts = (gen_ts - dt) & TIMER_MASK;
            ts = TS_W'(gen_ts);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_tracker_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing pending, full_angle", o_full_angle, 0);
            end else begin
                want = expected_q.pop_front();
                results_checked++;
                if (want.velocity_saturated)
                    sat_results++;
                if (want.interval_fallback)
                    fb_results++;
                if (o_full_angle !== want.full_angle)
                    report_mismatch("full_angle", o_full_angle, want.full_angle);
                if (o_velocity !== want.velocity)
                    report_mismatch("velocity", o_velocity, want.velocity);
                if (o_velocity_saturated !== want.velocity_saturated)
                    report_mismatch("velocity_saturated", o_velocity_saturated,
                                    want.velocity_saturated);
                if (o_interval_fallback !== want.interval_fallback)
                    report_mismatch("interval_fallback", o_interval_fallback,
                                    want.interval_fallback);
            end
        end
        i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    initial begin : stimulus
        logic [OP_W-1:0]  op;
        logic [RAW_W-1:0] raw;
        logic [TS_W-1:0]  ts;

        // default settings: 16384 counts, 9 ticks/us, 4500000 max, 9000 fallback
        add_row(OP_ANGLE, 16'd0,     24'd0,        1'b1, 48'sd0,     32'sd0, 1'b0, 1'b0);
        add_row(OP_ANGLE, 16'd100,   24'd0,        1'b1, 48'sd100,   32'sd0, 1'b0, 1'b0);
        add_row(OP_ANGLE, 16'd16383, 24'd0,        1'b1, -48'sd1,    32'sd0, 1'b0, 1'b0);
        add_row(OP_ANGLE, 16'd0,     24'd0,        1'b1, 48'sd0,     32'sd0, 1'b0, 1'b0);
        add_row(OP_INIT,  16'hFFFF,  24'd123,      1'b1, 48'sd65535, 32'sd0, 1'b0, 1'b0);
        // zero interval right after init
        add_row(OP_VEL,   16'hFFFF,  24'hFF_FFFF,  1'b1, 48'sd65535, 32'sd0, 1'b0, 1'b1);
        add_row(OP_INIT,  16'd0,     24'd0,        1'b1, 48'sd0,     32'sd0, 1'b0, 1'b0);
        add_row(OP_VEL,   16'd9,     24'd16768215, 1'b1, 48'sd9,     32'sd9000, 1'b0, 1'b0);
        // equal timestamps give a full-period interval, too long
        add_row(OP_VEL,   16'd0,     24'd16768215, 1'b1, 48'sd0,     -32'sd9000, 1'b0, 1'b1);
        add_row(OP_VEL,   16'd16383, 24'd16768206, 1'b1, -48'sd1,    -32'sd1000000, 1'b0, 1'b0);
        add_row(OP_VEL,   16'd16000, 24'd16768205, 1'b1, -48'sd384,  VEL_NEG_LIM, 1'b1, 1'b0);
        add_row(OP_VEL,   16'd16383, 24'd16768204, 1'b1, -48'sd1,    VEL_POS_LIM, 1'b1, 1'b0);
        add_row(OP_VEL,   16'd16383, 24'd5,        1'b1, -48'sd1,    32'sd0, 1'b0, 1'b1);
        // timer wraps through zero
        add_row(OP_VEL,   16'd16382, 24'd16777211, 1'b1, -48'sd2,    -32'sd1000000, 1'b0, 1'b0);
        add_row(OP_SPARE, 16'd0,     24'd0,        1'b1, 48'sd0,     32'sd0, 1'b0, 1'b0);
        add_row(OP_ANGLE, 16'hFFFF,  24'hFF_FFFF,  1'b1, 48'sd49151, 32'sd0, 1'b0, 1'b0);
        add_row(OP_ANGLE, 16'd0,     24'd0,        1'b1, 48'sd0,     32'sd0, 1'b0, 1'b0);
        // jumps just under and just over the wrap threshold
        add_row(OP_ANGLE, 16'd13107, 24'd0,        1'b1, 48'sd13107, 32'sd0, 1'b0, 1'b0);
        add_row(OP_ANGLE, 16'd0,     24'd0,        1'b1, 48'sd0,     32'sd0, 1'b0, 1'b0);
        add_row(OP_ANGLE, 16'd13108, 24'd0,        1'b1, -48'sd3276, 32'sd0, 1'b0, 1'b0);
        add_row(OP_ANGLE, 16'd0,     24'd0,        1'b1, 48'sd0,     32'sd0, 1'b0, 1'b0);
        add_row(OP_VEL,   16'd5000,  24'd12345,    1'b0, '0,         '0,     1'b0, 1'b0);
        add_row(OP_VEL,   16'd6000,  24'd3000,     1'b0, '0,         '0,     1'b0, 1'b0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].raw, directed_rows[i].ts,
                      directed_rows[i].known, directed_rows[i].res);

        gen_ts = $urandom_range(0, 24'hFF_FFFF);
        for (int b = 0; b < SETTINGS_COUNT; b++) begin
            drain_results();
            case (b)
                0: load_settings(CPR_RST, TPU_RST, MAXI_RST, FB_RST);
                1: load_settings(24'd4096, 24'd1, 24'hFF_FFFF, 24'd1);
                2: load_settings(24'd65536, 24'd255, 24'd20000, 24'hFF_FFFF);
                3: load_settings(24'd2, 24'd100, 24'd0, 24'd0);
                4: load_settings(24'h01_FFFF, 24'd0, 24'd5000, 24'd3);
                default: load_settings(24'd0, 24'd37, 24'd1, 24'd2);
            endcase
            snd_idle_pct = (b < 2) ? 18 : (b < 4) ? 57 : 0;
            rcv_idle_pct = (b < 2) ? 57 : (b < 4) ? 18 : 0;
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                next_random_item(op, raw, ts);
                send_item(op, raw, ts, 1'b0, '0);
            end
        end
        drain_results();

        $display("items: %0d angle, %0d velocity, %0d init, %0d spare code; %0d results checked",
                 op_seen[OP_ANGLE], op_seen[OP_VEL], op_seen[OP_INIT], op_seen[OP_SPARE],
                 results_checked);
        $display("%0d saturated and %0d fallback velocities over %0d register settings",
                 sat_results, fb_results, SETTINGS_COUNT);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
